// ===== sv/dlrs_pkg.sv =====
// Shared types, codes and default sizes of the dense layer with ReLU and gradient descent.
package dlrs_pkg;

	// Default sizes handed to the top-level parameters.
	localparam int DEF_INPUT_COUNT = 16;
	localparam int DEF_NEURON_COUNT = 16;
	localparam int DEF_BATCH_SLOTS = 8;
	localparam int DEF_VALUE_BITS = 16;

	// Fixed field widths of the request and result.
	localparam int FUNC_BITS = 2;
	localparam int IDX_BITS = 4;
	localparam int SLOT_BITS = 3;

	// Fixed-point layout and update scaling.
	localparam int FRAC_BITS = 12;
	localparam int STEP_BITS = 16;
	localparam int UPD_W_SHIFT = FRAC_BITS + STEP_BITS;
	localparam int UPD_B_SHIFT = STEP_BITS;

	// Configuration port.
	localparam int CFG_IDX_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELU_ENABLE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SCALE = 1'd1;
	localparam logic RELU_RESET = 1'b1;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd655;

	// Result kinds.
	localparam logic KIND_FORWARD = 1'b0;
	localparam logic KIND_BACKWARD = 1'b1;

	// Request function codes.
	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_WEIGHT = 2'd0,
		FUNC_BIAS = 2'd1,
		FUNC_FORWARD = 2'd2,
		FUNC_BACKWARD = 2'd3
	} func_t;

endpackage

// ===== sv/dense_layer_relu_sgd_top.sv =====
// Top level of the fully connected layer with ReLU and gradient-descent training.
//
// One request is taken at a time; in_ready is high only while the block is idle. Every pass
// over a request goes through one shared multiplier and the state memories in the phases
// read, multiply and write back for each element. A weight or bias write is done when it is
// accepted; a forward element makes a pass over the neurons, and the last element of a vector
// adds a pass that makes the outputs; a backward element makes a delta step and a pass over
// the inputs; the last element of a vector adds the input-gradient pass over all weights, and
// the last element of a batch adds the update pass over all weights and biases. Output stalls
// hold the output passes. After reset a clearing pass zeroes the accumulators and gradient
// sums before the first request is taken; configuration writes are accepted at any time.
module dense_layer_relu_sgd_top #(
	parameter int INPUT_COUNT = dlrs_pkg::DEF_INPUT_COUNT,
	parameter int NEURON_COUNT = dlrs_pkg::DEF_NEURON_COUNT,
	parameter int BATCH_SLOTS = dlrs_pkg::DEF_BATCH_SLOTS,
	parameter int VALUE_BITS = dlrs_pkg::DEF_VALUE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [dlrs_pkg::FUNC_BITS-1:0] func,
	input  logic [dlrs_pkg::IDX_BITS-1:0] neuron_index,
	input  logic [dlrs_pkg::IDX_BITS-1:0] input_index,
	input  logic [dlrs_pkg::SLOT_BITS-1:0] sample_slot,
	input  logic signed [VALUE_BITS-1:0] value,
	input  logic last_of_vector,
	input  logic last_of_batch,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [VALUE_BITS-1:0] result_value,
	output logic [dlrs_pkg::IDX_BITS-1:0] result_index,
	output logic result_kind,
	output logic last_result,
	input  logic cfg_we,
	input  logic [dlrs_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [dlrs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import dlrs_pkg::*;

	localparam int ACC_BITS = (2 * VALUE_BITS < 48) ? 2 * VALUE_BITS : 48;
	localparam int MB_BITS = (VALUE_BITS > STEP_BITS + 1) ? VALUE_BITS : STEP_BITS + 1;
	localparam int P_BITS = ACC_BITS + MB_BITS;
	localparam int X_BITS = P_BITS + 2;
	localparam int NW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
	localparam int IW = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
	localparam int KW = (NEURON_COUNT * INPUT_COUNT > 1) ?
		$clog2(NEURON_COUNT * INPUT_COUNT) : 1;
	localparam int XAW = (BATCH_SLOTS * INPUT_COUNT > 1) ?
		$clog2(BATCH_SLOTS * INPUT_COUNT) : 1;
	localparam int ZAW = (BATCH_SLOTS * NEURON_COUNT > 1) ?
		$clog2(BATCH_SLOTS * NEURON_COUNT) : 1;

	typedef enum logic [9:0] {
		ST_CLEAR = 10'b0000000001,
		ST_IDLE  = 10'b0000000010,
		ST_FACC  = 10'b0000000100,
		ST_FOUT  = 10'b0000001000,
		ST_BDEL  = 10'b0000010000,
		ST_BWG   = 10'b0000100000,
		ST_BIG   = 10'b0001000000,
		ST_BEMIT = 10'b0010000000,
		ST_UPW   = 10'b0100000000,
		ST_UPB   = 10'b1000000000
	} state_t;

	typedef enum logic [2:0] {
		PH_RD = 3'b001,
		PH_DT = 3'b010,
		PH_WB = 3'b100
	} phase_t;

	// Saturate a wide sum to the accumulator width.
	function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [X_BITS-1:0] x);
		logic signed [X_BITS-1:0] hi;
		logic signed [X_BITS-1:0] lo;
		hi = {{(X_BITS - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[ACC_BITS-1:0];
		end else if (x < lo) begin
			return lo[ACC_BITS-1:0];
		end
		return x[ACC_BITS-1:0];
	endfunction

	// Saturate a wide value to the Q4.12 width.
	function automatic logic signed [VALUE_BITS-1:0] sat_val(input logic signed [X_BITS-1:0] x);
		logic signed [X_BITS-1:0] hi;
		logic signed [X_BITS-1:0] lo;
		hi = {{(X_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
		lo = ~hi;
		if (x > hi) begin
			return hi[VALUE_BITS-1:0];
		end else if (x < lo) begin
			return lo[VALUE_BITS-1:0];
		end
		return x[VALUE_BITS-1:0];
	endfunction

	state_t state_q;
	phase_t ph_q;
	logic [NW-1:0] a_q;
	logic [IW-1:0] b_q;
	logic [KW-1:0] k_q;
	logic a_last, b_last, k_last, wb, k_in_n;

	// Request fields held for the duration of the request.
	logic [IDX_BITS-1:0] n_q, i_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic signed [VALUE_BITS-1:0] v_q;
	logic lv_q, lb_q, sok_q;

	// Datapath registers.
	logic signed [P_BITS-1:0] prod_q;
	logic signed [ACC_BITS-1:0] oth_q, s_q;
	logic signed [VALUE_BITS-1:0] d_q;

	logic relu_q;
	logic [STEP_BITS-1:0] step_q;

	logic in_acc, n_ok, i_ok, s_ok;
	func_t fn;

	logic out_valid_q, out_free, out_load;
	logic signed [VALUE_BITS-1:0] res_value_q;
	logic [IDX_BITS-1:0] res_index_q;
	logic res_kind_q, res_last_q;

	// Memory ports.
	logic w_we, b_we, x_we, z_we, am_we, dm_we, g_we, c_we;
	logic [KW-1:0] w_waddr, w_raddr, g_addr;
	logic [NW-1:0] b_waddr, am_waddr, dm_waddr, c_waddr, c_raddr;
	logic [XAW-1:0] x_waddr, x_raddr;
	logic [ZAW-1:0] z_waddr, z_raddr;
	logic [VALUE_BITS-1:0] w_wdata, b_wdata, z_wdata, dm_wdata;
	logic [ACC_BITS-1:0] am_wdata, g_wdata, c_wdata;
	logic [VALUE_BITS-1:0] w_rd, b_rd, x_rd, z_rd, dl_rd;
	logic [ACC_BITS-1:0] am_rd, g_rd, c_rd;

	// Datapath combinational values.
	logic signed [ACC_BITS-1:0] mul_a, oth_d, acc_new, c_new, s_new;
	logic signed [MB_BITS-1:0] mul_b;
	logic signed [VALUE_BITS-1:0] z_rd_s, d_new, z_new, upd_new, ig_new;

	assign fn = func_t'(func);
	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign n_ok = 32'(neuron_index) < NEURON_COUNT;
	assign i_ok = 32'(input_index) < INPUT_COUNT;
	assign s_ok = 32'(sample_slot) < BATCH_SLOTS;

	assign a_last = (a_q == NW'(NEURON_COUNT - 1));
	assign b_last = (b_q == IW'(INPUT_COUNT - 1));
	assign k_last = (k_q == KW'(NEURON_COUNT * INPUT_COUNT - 1));
	assign k_in_n = 32'(k_q) < NEURON_COUNT;
	assign wb = (ph_q == PH_WB);

	assign out_free = !out_valid_q || out_ready;
	assign out_load = ((state_q == ST_FOUT) && wb && out_free) ||
		((state_q == ST_BEMIT) && out_free);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_q <= RELU_RESET;
			step_q <= STEP_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_RELU_ENABLE) begin
				relu_q <= cfg_data[0];
			end else if (cfg_index == REG_STEP_SCALE) begin
				step_q <= cfg_data[STEP_BITS-1:0];
			end
		end
	end

	// Read addresses follow the pass counters.
	always_comb begin
		w_raddr = KW'(32'(a_q) * INPUT_COUNT + 32'(i_q));
		if (state_q == ST_BIG) begin
			w_raddr = KW'(32'(a_q) * INPUT_COUNT + 32'(b_q));
		end else if (state_q == ST_UPW) begin
			w_raddr = k_q;
		end
		g_addr = k_q;
		if (state_q == ST_BWG) begin
			g_addr = KW'(32'(n_q) * INPUT_COUNT + 32'(b_q));
		end
		c_raddr = (state_q == ST_BDEL) ? NW'(n_q) : a_q;
		x_raddr = XAW'(32'(slot_q) * INPUT_COUNT + 32'(b_q));
		z_raddr = ZAW'(32'(slot_q) * NEURON_COUNT + 32'(n_q));
		z_waddr = ZAW'(32'(slot_q) * NEURON_COUNT + 32'(a_q));
	end

	// Multiplier operands and the captured second operand for each pass.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		oth_d = '0;
		unique case (state_q)
			ST_FACC: begin
				mul_a = ACC_BITS'($signed(w_rd));
				mul_b = MB_BITS'(v_q);
				oth_d = $signed(am_rd);
			end
			ST_FOUT: begin
				mul_a = ACC_BITS'($signed(b_rd));
				mul_b = MB_BITS'(1 << FRAC_BITS);
				oth_d = $signed(am_rd);
			end
			ST_BDEL: begin
				oth_d = $signed(c_rd);
			end
			ST_BWG: begin
				mul_a = ACC_BITS'(d_q);
				mul_b = sok_q ? MB_BITS'($signed(x_rd)) : '0;
				oth_d = $signed(g_rd);
			end
			ST_BIG: begin
				mul_a = ACC_BITS'($signed(w_rd));
				mul_b = MB_BITS'($signed(dl_rd));
			end
			ST_UPW: begin
				mul_a = $signed(g_rd);
				mul_b = MB_BITS'({1'b0, step_q});
				oth_d = ACC_BITS'($signed(w_rd));
			end
			ST_UPB: begin
				mul_a = $signed(c_rd);
				mul_b = MB_BITS'({1'b0, step_q});
				oth_d = ACC_BITS'($signed(b_rd));
			end
			default: begin
			end
		endcase
	end

	// Write-back arithmetic.
	always_comb begin
		z_rd_s = sok_q ? $signed(z_rd) : '0;
		d_new = (relu_q && (z_rd_s <= 0)) ? '0 : v_q;
		acc_new = sat_acc(X_BITS'(oth_q) + X_BITS'(prod_q));
		c_new = sat_acc(X_BITS'(oth_q) + X_BITS'(d_q));
		s_new = sat_acc(X_BITS'(s_q) + X_BITS'(prod_q));
		z_new = sat_val(X_BITS'(acc_new) >>> FRAC_BITS);
		ig_new = sat_val(X_BITS'(s_q) >>> FRAC_BITS);
		if (state_q == ST_UPB) begin
			upd_new = sat_val(X_BITS'(oth_q) - (X_BITS'(prod_q) >>> UPD_B_SHIFT));
		end else begin
			upd_new = sat_val(X_BITS'(oth_q) - (X_BITS'(prod_q) >>> UPD_W_SHIFT));
		end
	end

	// Memory write ports.
	always_comb begin
		w_we = (in_acc && fn == FUNC_WEIGHT && n_ok && i_ok) || (state_q == ST_UPW && wb);
		w_waddr = (state_q == ST_UPW) ? k_q :
			KW'(32'(neuron_index) * INPUT_COUNT + 32'(input_index));
		w_wdata = (state_q == ST_UPW) ? upd_new : value;

		b_we = (in_acc && fn == FUNC_BIAS && n_ok) || (state_q == ST_UPB && wb);
		b_waddr = (state_q == ST_UPB) ? a_q : NW'(neuron_index);
		b_wdata = (state_q == ST_UPB) ? upd_new : value;

		x_we = in_acc && fn == FUNC_FORWARD && i_ok && s_ok;
		x_waddr = XAW'(32'(sample_slot) * INPUT_COUNT + 32'(input_index));

		z_we = (state_q == ST_FOUT) && wb && out_free && sok_q;
		z_wdata = z_new;

		am_we = (state_q == ST_CLEAR && k_in_n) || (state_q == ST_FACC && wb) ||
			(state_q == ST_FOUT && wb && out_free);
		am_waddr = (state_q == ST_CLEAR) ? NW'(k_q) : a_q;
		am_wdata = (state_q == ST_FACC) ? acc_new : '0;

		dm_we = (state_q == ST_CLEAR && k_in_n) || (state_q == ST_BDEL && wb) ||
			(state_q == ST_BIG && wb && b_last);
		dm_waddr = (state_q == ST_CLEAR) ? NW'(k_q) :
			((state_q == ST_BDEL) ? NW'(n_q) : a_q);
		dm_wdata = (state_q == ST_BDEL) ? d_q : '0;

		g_we = (state_q == ST_CLEAR) || (state_q == ST_BWG && wb) || (state_q == ST_UPW && wb);
		g_wdata = (state_q == ST_BWG) ? acc_new : '0;

		c_we = (state_q == ST_CLEAR && k_in_n) || (state_q == ST_BDEL && wb) ||
			(state_q == ST_UPB && wb);
		c_waddr = (state_q == ST_CLEAR) ? NW'(k_q) :
			((state_q == ST_BDEL) ? NW'(n_q) : a_q);
		c_wdata = (state_q == ST_BDEL) ? c_new : '0;
	end

	// Sequencer: passes over the memories, three phases per element outside the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ph_q <= PH_RD;
			a_q <= '0;
			b_q <= '0;
			k_q <= '0;
		end else begin
			if (ph_q == PH_RD) begin
				ph_q <= PH_DT;
			end else if (ph_q == PH_DT) begin
				ph_q <= PH_WB;
			end
			unique case (state_q)
				ST_CLEAR: begin
					ph_q <= PH_RD;
					k_q <= k_q + 1'b1;
					if (k_last) begin
						k_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					ph_q <= PH_RD;
					a_q <= '0;
					b_q <= '0;
					k_q <= '0;
					if (in_acc) begin
						if (fn == FUNC_FORWARD) begin
							if (i_ok) begin
								state_q <= ST_FACC;
							end else if (last_of_vector) begin
								state_q <= ST_FOUT;
							end
						end else if (fn == FUNC_BACKWARD) begin
							if (n_ok) begin
								state_q <= ST_BDEL;
							end else if (last_of_vector) begin
								state_q <= ST_BIG;
							end else if (last_of_batch) begin
								state_q <= ST_UPW;
							end
						end
					end
				end
				ST_FACC: begin
					if (wb) begin
						ph_q <= PH_RD;
						a_q <= a_q + 1'b1;
						if (a_last) begin
							a_q <= '0;
							state_q <= lv_q ? ST_FOUT : ST_IDLE;
						end
					end
				end
				ST_FOUT: begin
					if (wb) begin
						ph_q <= PH_WB;
						if (out_free) begin
							ph_q <= PH_RD;
							a_q <= a_q + 1'b1;
							if (a_last) begin
								a_q <= '0;
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_BDEL: begin
					if (wb) begin
						ph_q <= PH_RD;
						b_q <= '0;
						state_q <= ST_BWG;
					end
				end
				ST_BWG: begin
					if (wb) begin
						ph_q <= PH_RD;
						b_q <= b_q + 1'b1;
						if (b_last) begin
							b_q <= '0;
							a_q <= '0;
							k_q <= '0;
							if (lv_q) begin
								state_q <= ST_BIG;
							end else if (lb_q) begin
								state_q <= ST_UPW;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_BIG: begin
					if (wb) begin
						ph_q <= PH_RD;
						a_q <= a_q + 1'b1;
						if (a_last) begin
							a_q <= '0;
							state_q <= ST_BEMIT;
						end
					end
				end
				ST_BEMIT: begin
					ph_q <= PH_RD;
					if (out_free) begin
						a_q <= '0;
						b_q <= b_q + 1'b1;
						state_q <= ST_BIG;
						if (b_last) begin
							b_q <= '0;
							k_q <= '0;
							state_q <= lb_q ? ST_UPW : ST_IDLE;
						end
					end
				end
				ST_UPW: begin
					if (wb) begin
						ph_q <= PH_RD;
						k_q <= k_q + 1'b1;
						if (k_last) begin
							k_q <= '0;
							a_q <= '0;
							state_q <= ST_UPB;
						end
					end
				end
				ST_UPB: begin
					if (wb) begin
						ph_q <= PH_RD;
						a_q <= a_q + 1'b1;
						if (a_last) begin
							a_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ph_q <= PH_RD;
				end
			endcase
		end
	end

	// Request capture and datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q <= neuron_index;
			i_q <= input_index;
			slot_q <= sample_slot;
			v_q <= value;
			lv_q <= last_of_vector;
			lb_q <= last_of_batch;
			sok_q <= s_ok;
		end
		if (ph_q == PH_DT) begin
			prod_q <= mul_a * mul_b;
			oth_q <= oth_d;
			if (state_q == ST_BDEL) begin
				d_q <= d_new;
			end
		end
		// The input-gradient sum restarts for every input column.
		if (state_q == ST_IDLE || state_q == ST_BWG || (state_q == ST_BEMIT && out_free)) begin
			s_q <= '0;
		end else if (state_q == ST_BIG && wb) begin
			s_q <= s_new;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == ST_FOUT) begin
				res_value_q <= (relu_q && z_new < 0) ? '0 : z_new;
				res_index_q <= IDX_BITS'(a_q);
				res_kind_q <= KIND_FORWARD;
				res_last_q <= a_last;
			end else begin
				res_value_q <= ig_new;
				res_index_q <= IDX_BITS'(b_q);
				res_kind_q <= KIND_BACKWARD;
				res_last_q <= b_last;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_value = res_value_q;
	assign result_index = res_index_q;
	assign result_kind = res_kind_q;
	assign last_result = res_last_q;

	// State memories.
	dlrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(NEURON_COUNT * INPUT_COUNT)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rd)
	);
	dlrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(NEURON_COUNT)) u_bias (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(a_q), .rdata(b_rd)
	);
	dlrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(BATCH_SLOTS * INPUT_COUNT)) u_inputs (
		.clk(clk), .we(x_we), .waddr(x_waddr), .wdata(value), .raddr(x_raddr), .rdata(x_rd)
	);
	dlrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(BATCH_SLOTS * NEURON_COUNT)) u_sums (
		.clk(clk), .we(z_we), .waddr(z_waddr), .wdata(z_wdata), .raddr(z_raddr), .rdata(z_rd)
	);
	dlrs_ram #(.WIDTH(ACC_BITS), .DEPTH(NEURON_COUNT)) u_acc (
		.clk(clk), .we(am_we), .waddr(am_waddr), .wdata(am_wdata), .raddr(a_q), .rdata(am_rd)
	);
	dlrs_ram #(.WIDTH(VALUE_BITS), .DEPTH(NEURON_COUNT)) u_delta (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata), .raddr(a_q), .rdata(dl_rd)
	);
	dlrs_ram #(.WIDTH(ACC_BITS), .DEPTH(NEURON_COUNT * INPUT_COUNT)) u_wgrad (
		.clk(clk), .we(g_we), .waddr(g_addr), .wdata(g_wdata), .raddr(g_addr), .rdata(g_rd)
	);
	dlrs_ram #(.WIDTH(ACC_BITS), .DEPTH(NEURON_COUNT)) u_bgrad (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rd)
	);

	// A result is only produced by the output passes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (state_q == ST_FOUT || state_q == ST_BEMIT))
		else $error("result loaded outside an output pass");

	// A waiting result is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	// The last forward output returns the block to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && state_q == ST_FOUT && a_last) |=> (state_q == ST_IDLE))
		else $error("forward pass did not end after the last neuron");

endmodule

// ===== sv/dlrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module dlrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/dense_layer_check.sv =====
// Checker of the dense layer: watches both channels, predicts the results and compares them.
module dense_layer_check
	import dlrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [FUNC_BITS-1:0] func,
	input  logic [IDX_BITS-1:0] neuron_index,
	input  logic [IDX_BITS-1:0] input_index,
	input  logic [SLOT_BITS-1:0] sample_slot,
	input  logic signed [DEF_VALUE_BITS-1:0] value,
	input  logic last_of_vector,
	input  logic last_of_batch,
	input  logic out_valid,
	input  logic out_ready,
	input  logic signed [DEF_VALUE_BITS-1:0] result_value,
	input  logic [IDX_BITS-1:0] result_index,
	input  logic result_kind,
	input  logic last_result,
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int errors,
	output int pending
);

	localparam int INPUTS = DEF_INPUT_COUNT;
	localparam int NEURONS = DEF_NEURON_COUNT;
	localparam int SLOTS = DEF_BATCH_SLOTS;
	localparam longint VAL_MAX = 32767;
	localparam longint VAL_MIN = -32768;
	localparam longint SUM_MAX = 64'sd2147483647;
	localparam longint SUM_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [DEF_VALUE_BITS-1:0] val;
		logic [IDX_BITS-1:0] idx;
		logic kind;
		logic last;
	} layer_result_t;

	layer_result_t expected_results[$];

	// Shadow copy of the layer state and its registers.
	longint weights[NEURONS*INPUTS];
	longint biases[NEURONS];
	longint inputs_saved[SLOTS*INPUTS];
	longint sums_saved[SLOTS*NEURONS];
	longint neuron_acc[NEURONS];
	longint deltas[NEURONS];
	longint weight_grads[NEURONS*INPUTS];
	longint bias_grads[NEURONS];
	logic relu_on;
	logic [STEP_BITS-1:0] step;

	function automatic longint clamp16(input longint x);
		return x > VAL_MAX ? VAL_MAX : (x < VAL_MIN ? VAL_MIN : x);
	endfunction

	function automatic longint sum_add(input longint a, input longint b);
		longint s;
		s = a + b;
		return s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
	endfunction

	// floor(a * step / 2^(k + 16)), split so that nothing overflows.
	function automatic longint scaled_step(input longint a, input longint st, input int k);
		longint q;
		longint r;
		q = a >>> k;
		r = a & ((64'sd1 <<< k) - 1);
		return (q * st + ((r * st) >>> k)) >>> 16;
	endfunction

	function automatic void push_result(input longint v, input int idx, input logic kind,
			input logic last);
		layer_result_t r;
		r.val = v[DEF_VALUE_BITS-1:0];
		r.idx = idx[IDX_BITS-1:0];
		r.kind = kind;
		r.last = last;
		expected_results.push_back(r);
	endfunction

	// Works out the state change and the results of one accepted request.
	task automatic predict_request(input func_t f, input int n, input int i, input int s,
			input longint v, input logic lv, input logic lb);
		longint t;
		longint z;
		longint d;
		longint acc;
		case (f)
			FUNC_WEIGHT: weights[n*INPUTS+i] = v;
			FUNC_BIAS: biases[n] = v;
			FUNC_FORWARD: begin
				inputs_saved[s*INPUTS+i] = v;
				for (int a = 0; a < NEURONS; a++)
					neuron_acc[a] = sum_add(neuron_acc[a], weights[a*INPUTS+i] * v);
				if (lv) begin
					for (int a = 0; a < NEURONS; a++) begin
						t = sum_add(neuron_acc[a], biases[a] * 4096);
						z = clamp16(t >>> FRAC_BITS);
						sums_saved[s*NEURONS+a] = z;
						push_result((relu_on && z < 0) ? 0 : z, a, KIND_FORWARD,
							a == NEURONS - 1);
						neuron_acc[a] = 0;
					end
				end
			end
			FUNC_BACKWARD: begin
				z = sums_saved[s*NEURONS+n];
				d = (relu_on && z <= 0) ? 0 : v;
				deltas[n] = d;
				bias_grads[n] = sum_add(bias_grads[n], d);
				for (int b = 0; b < INPUTS; b++)
					weight_grads[n*INPUTS+b] = sum_add(weight_grads[n*INPUTS+b],
						d * inputs_saved[s*INPUTS+b]);
				if (lv) begin
					for (int b = 0; b < INPUTS; b++) begin
						acc = 0;
						for (int a = 0; a < NEURONS; a++)
							acc = sum_add(acc, weights[a*INPUTS+b] * deltas[a]);
						push_result(clamp16(acc >>> FRAC_BITS), b, KIND_BACKWARD,
							b == INPUTS - 1);
					end
					for (int a = 0; a < NEURONS; a++)
						deltas[a] = 0;
				end
				if (lb) begin
					for (int a = 0; a < NEURONS; a++) begin
						for (int b = 0; b < INPUTS; b++) begin
							weights[a*INPUTS+b] = clamp16(weights[a*INPUTS+b] -
								scaled_step(weight_grads[a*INPUTS+b], longint'(step),
									FRAC_BITS));
							weight_grads[a*INPUTS+b] = 0;
						end
						biases[a] = clamp16(biases[a] -
							scaled_step(bias_grads[a], longint'(step), 0));
						bias_grads[a] = 0;
					end
				end
			end
		endcase
	endtask

	initial begin
		errors = 0;
		relu_on = RELU_RESET;
		step = STEP_RESET;
		for (int k = 0; k < NEURONS*INPUTS; k++) begin
			weights[k] = 0;
			weight_grads[k] = 0;
		end
		for (int k = 0; k < NEURONS; k++) begin
			biases[k] = 0;
			neuron_acc[k] = 0;
			deltas[k] = 0;
			bias_grads[k] = 0;
		end
		for (int k = 0; k < SLOTS*INPUTS; k++)
			inputs_saved[k] = 0;
		for (int k = 0; k < SLOTS*NEURONS; k++)
			sums_saved[k] = 0;
	end

	assign pending = expected_results.size();

	// Results are compared before the request of the same edge is predicted.
	always @(posedge clk) begin
		layer_result_t exp_r;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_RELU_ENABLE)
					relu_on = cfg_data[0];
				else if (cfg_index == REG_STEP_SCALE)
					step = cfg_data[STEP_BITS-1:0];
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result: value %0d index %0d kind %0d last %0d",
							result_value, result_index, result_kind, last_result);
				end else begin
					exp_r = expected_results.pop_front();
					if (exp_r.val !== result_value || exp_r.idx !== result_index ||
							exp_r.kind !== result_kind || exp_r.last !== last_result) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								$signed(exp_r.val), exp_r.idx, exp_r.kind, exp_r.last,
								result_value, result_index, result_kind, last_result);
					end
				end
			end
			if (in_valid && in_ready)
				predict_request(func_t'(func), int'(neuron_index), int'(input_index),
					int'(sample_slot), longint'(value), last_of_vector, last_of_batch);
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top of the dense layer: makes the requests and register writes and gives the verdict.
module tb;
	import dlrs_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [FUNC_BITS-1:0] func;
	logic [IDX_BITS-1:0] neuron_index;
	logic [IDX_BITS-1:0] input_index;
	logic [SLOT_BITS-1:0] sample_slot;
	logic signed [DEF_VALUE_BITS-1:0] value;
	logic last_of_vector;
	logic last_of_batch;
	logic out_valid;
	logic out_ready;
	logic signed [DEF_VALUE_BITS-1:0] result_value;
	logic [IDX_BITS-1:0] result_index;
	logic result_kind;
	logic last_result;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	int errors;
	int pending;

	int send_idle;
	int recv_idle;
	int sent;
	logic [DEF_INPUT_COUNT-1:0] inputs_written[DEF_BATCH_SLOTS];
	logic sums_written[DEF_BATCH_SLOTS];

	dense_layer_relu_sgd_top uut (.*);

	dense_layer_check checker_i (.*);

	always #1 clk = ~clk;

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	initial begin
		#4000000;
		$display("** dense_layer_relu_sgd_top: FAILED **");
		$finish;
	end

	// Mostly moderate values, sometimes any value, sometimes an extreme.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2, 3: return 16'($urandom());
			default: return 16'($urandom_range(8192)) - 16'd4096;
		endcase
	endfunction

	// One request; valid stays high into the next request unless the sender idles.
	task automatic send(input func_t f, input int n, input int i, input int s,
			input logic [15:0] v, input logic lv, input logic lb);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		neuron_index <= IDX_BITS'(n);
		input_index <= IDX_BITS'(i);
		sample_slot <= SLOT_BITS'(s);
		value <= v;
		last_of_vector <= lv;
		last_of_batch <= lb;
		if (f == FUNC_FORWARD) begin
			inputs_written[s][i] = 1'b1;
			if (lv)
				sums_written[s] = 1'b1;
		end
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for all results, then for an update pass that leaves no result.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// A forward vector in shuffled order; a partial one now and then.
	task automatic forward_vector(input int s, input int len);
		int order[DEF_INPUT_COUNT];
		int j;
		int t;
		for (int k = 0; k < DEF_INPUT_COUNT; k++)
			order[k] = k;
		for (int k = DEF_INPUT_COUNT - 1; k > 0; k--) begin
			j = $urandom_range(k);
			t = order[k];
			order[k] = order[j];
			order[j] = t;
		end
		for (int k = 0; k < len; k++)
			send(FUNC_FORWARD, 0, order[k], s, pick_value(), k == len - 1,
				1'($urandom_range(1)));
	endtask

	function automatic int ready_slot();
		int s;
		do s = $urandom_range(DEF_BATCH_SLOTS - 1);
		while (!(&inputs_written[s]) || !sums_written[s]);
		return s;
	endfunction

	// A backward vector over slots that hold full inputs and sums.
	task automatic backward_vector(input logic close_vector);
		int len;
		len = $urandom_range(1, 6);
		for (int k = 0; k < len; k++)
			send(FUNC_BACKWARD, $urandom_range(15), $urandom_range(15), ready_slot(),
				pick_value(), close_vector && k == len - 1,
				1'((k == len - 1) ? $urandom_range(1) : ($urandom_range(7) == 0)));
	endtask

	task automatic random_phase(input int count);
		int r;
		int goal;
		goal = sent + count;
		while (sent < goal) begin
			r = $urandom_range(19);
			if (r < 8)
				forward_vector($urandom_range(DEF_BATCH_SLOTS - 1), DEF_INPUT_COUNT);
			else if (r < 9)
				forward_vector($urandom_range(DEF_BATCH_SLOTS - 1), $urandom_range(1, 5));
			else if (r < 16)
				backward_vector(1'b1);
			else if (r < 17)
				backward_vector(1'b0);
			else
				send(func_t'($urandom_range(1)), $urandom_range(15), $urandom_range(15),
					$urandom_range(7), pick_value(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_WEIGHT;
		neuron_index <= '0;
		input_index <= '0;
		sample_slot <= '0;
		value <= '0;
		last_of_vector <= 1'b0;
		last_of_batch <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RELU_ENABLE;
		cfg_data <= '0;
		send_idle = 30;
		recv_idle = 70;
		sent = 0;
		for (int s = 0; s < DEF_BATCH_SLOTS; s++) begin
			inputs_written[s] = '0;
			sums_written[s] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every weight and bias is written before anything reads it.
		for (int n = 0; n < DEF_NEURON_COUNT; n++) begin
			for (int i = 0; i < DEF_INPUT_COUNT; i++)
				send(FUNC_WEIGHT, n, i, 0, pick_value(), 1'b0, 1'b0);
			send(FUNC_BIAS, n, 0, 0, pick_value(), 1'b0, 1'b0);
		end

		// Directed: extremes, marks on writes, repeated gradient, update with no result.
		send(FUNC_WEIGHT, 15, 15, 7, 16'h7fff, 1'b1, 1'b1);
		send(FUNC_WEIGHT, 0, 0, 0, 16'h8000, 1'b1, 1'b0);
		send(FUNC_BIAS, 15, 0, 0, 16'h8000, 1'b1, 1'b1);
		forward_vector(7, DEF_INPUT_COUNT);
		send(FUNC_BACKWARD, 3, 0, 7, 16'h7fff, 1'b0, 1'b0);
		send(FUNC_BACKWARD, 3, 0, 7, 16'h8000, 1'b0, 1'b0);
		send(FUNC_BACKWARD, 0, 0, 7, 16'h1000, 1'b1, 1'b0);
		send(FUNC_BACKWARD, 15, 0, 7, 16'hf000, 1'b0, 1'b1);
		drain();

		// Phase with the sender mostly busy: ReLU off and no learning.
		write_reg(REG_RELU_ENABLE, 16'd0);
		write_reg(REG_STEP_SCALE, 16'd0);
		random_phase(40);
		drain();

		// Receiver mostly ready: ReLU on and the largest step.
		send_idle = 70;
		recv_idle = 30;
		write_reg(REG_RELU_ENABLE, 16'd1);
		write_reg(REG_STEP_SCALE, 16'hffff);
		random_phase(40);
		drain();

		// No idling on either side with a random step.
		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_STEP_SCALE, 16'($urandom()));
		random_phase(40);
		drain();

		if (errors == 0 && pending == 0)
			$display("** dense_layer_relu_sgd_top: PASSED **");
		else
			$display("** dense_layer_relu_sgd_top: FAILED **");
		$finish;
	end

endmodule
